### hdl/rsm_pkg.sv
package rsm_pkg;

    localparam int MOD_WIDTH = 16;
    localparam int EXP_WIDTH = 16;
    localparam int KW        = $clog2(EXP_WIDTH);

    // config register indexes
    localparam logic CFG_EXPONENT = 1'b0;
    localparam logic CFG_MODULUS  = 1'b1;

    localparam logic [EXP_WIDTH-1:0] EXP_RESET = 16'd1;
    localparam logic [MOD_WIDTH-1:0] MOD_RESET = 16'd2;

    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    localparam logic [7:0] LOWER_BASE = 8'd97;
    localparam logic [7:0] UPPER_BASE = 8'd65;
    localparam logic [7:0] LETTER_SPAN = 8'd25;
    localparam logic [7:0] TERMINATOR = 8'd35;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPW         = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [EXP_WIDTH-1:0] exponent;
        logic [MOD_WIDTH-1:0] modulus;
    } t_cfg;

    typedef struct packed {
        logic decrypt;
        logic last;
    } t_job_ctl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BASE,
        ST_SQR,
        ST_MUL,
        ST_FIN
    } t_eng_state;

endpackage

### hdl/rsm_front.sv
module rsm_front
    import rsm_pkg::*;
#(
    parameter int VALUE_WIDTH = 16
) (
    input  logic                   i_command,
    input  logic [VALUE_WIDTH-1:0] i_value,
    input  logic                   i_is_last,
    output logic                   o_drop,
    output logic [VALUE_WIDTH-1:0] o_base,
    output t_job_ctl               o_ctl
);

    logic [7:0] ch;
    logic [7:0] mapped;

    always_comb begin
        ch     = i_value[7:0];
        mapped = ch;
        o_drop = 1'b0;
        if (ch inside {[LOWER_BASE:LOWER_BASE + LETTER_SPAN]}) begin
            mapped = ch - LOWER_BASE;
        end else if (ch inside {[UPPER_BASE:UPPER_BASE + LETTER_SPAN]}) begin
            mapped = ch - UPPER_BASE;
        end else if (ch == TERMINATOR) begin
            o_drop = (i_command == CMD_ENCRYPT);
        end

        if (i_command == CMD_DECRYPT) begin
            o_base = i_value;
        end else begin
            o_base = VALUE_WIDTH'(mapped);
        end
        o_ctl.decrypt = (i_command == CMD_DECRYPT);
        o_ctl.last    = i_is_last;
    end

endmodule

### hdl/rsm_queue.sv
module rsm_queue
    import rsm_pkg::*;
#(
    parameter int W = 18
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_push_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_pop_data,
    output logic         o_empty
);

    logic [W-1:0]     r_mem [QUEUE_DEPTH];
    logic [QPW-1:0]   r_wr;
    logic [QPW-1:0]   r_rd;
    logic [QPW:0]     r_cnt;
    logic [QPW-1:0]   n_wr;
    logic [QPW-1:0]   n_rd;
    logic [QPW:0]     n_cnt;

    assign o_full     = (r_cnt == (QPW + 1)'(QUEUE_DEPTH));
    assign o_empty    = (r_cnt == '0);
    assign o_pop_data = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == QPW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == QPW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

endmodule

### hdl/rsm_engine.sv
module rsm_engine
    import rsm_pkg::*;
#(
    parameter int VALUE_WIDTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cfg                   i_cfg,
    input  logic                   i_q_valid,
    input  t_job_ctl               i_q_ctl,
    input  logic [VALUE_WIDTH-1:0] i_q_base,
    output logic                   o_q_pop,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [VALUE_WIDTH-1:0] o_result_value,
    output logic                   o_last_out
);

    localparam int CW = ($clog2(VALUE_WIDTH) > $clog2(MOD_WIDTH)) ?
                        $clog2(VALUE_WIDTH) : $clog2(MOD_WIDTH);
    localparam int SW = MOD_WIDTH + 2;

    t_eng_state             r_state;
    t_eng_state             n_state;
    logic [VALUE_WIDTH-1:0] r_v;
    t_job_ctl               r_ctl;
    logic [MOD_WIDTH-1:0]   r_r;
    logic [MOD_WIDTH-1:0]   r_a;
    logic [MOD_WIDTH-1:0]   r_y;
    logic [MOD_WIDTH-1:0]   r_b;
    logic [MOD_WIDTH-1:0]   r_acc;
    logic [KW-1:0]          r_k;
    logic [CW-1:0]          r_cnt;
    logic                   r_out_valid;
    logic [VALUE_WIDTH-1:0] r_res;
    logic                   r_olast;

    logic [SW-1:0]          addend;
    logic [SW-1:0]          m_ext;
    logic [SW-1:0]          t0;
    logic [SW-1:0]          t1;
    logic [SW-1:0]          t2;
    logic [MOD_WIDTH-1:0]   step_r;
    logic                   last_step;
    logic                   exp_bit;
    logic                   mod_ok;
    logic                   out_free;
    logic                   load;
    logic [7:0]             plain;
    logic [VALUE_WIDTH-1:0] result;

    // one shift-add-reduce step: r = 2r + addend mod m, r stays below m
    always_comb begin
        if (r_state == ST_BASE) begin
            addend = SW'(r_v[VALUE_WIDTH-1]);
        end else begin
            addend = r_y[MOD_WIDTH-1] ? SW'(r_a) : '0;
        end
        m_ext  = SW'(i_cfg.modulus);
        t0     = SW'({r_r, 1'b0}) + addend;
        t1     = (t0 >= m_ext) ? t0 - m_ext : t0;
        t2     = (t1 >= m_ext) ? t1 - m_ext : t1;
        step_r = t2[MOD_WIDTH-1:0];
    end

    assign last_step = (r_state == ST_BASE) ? (r_cnt == CW'(VALUE_WIDTH - 1))
                                            : (r_cnt == CW'(MOD_WIDTH - 1));
    assign exp_bit   = i_cfg.exponent[r_k];
    assign mod_ok    = (i_cfg.modulus >= MOD_WIDTH'(2));
    assign out_free  = !r_out_valid || i_ready;
    assign plain     = r_acc[7:0] + LOWER_BASE;
    assign result    = r_ctl.decrypt ? VALUE_WIDTH'(plain) : VALUE_WIDTH'(r_acc);

    always_comb begin
        n_state = r_state;
        o_q_pop = 1'b0;
        load    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_state = mod_ok ? ST_BASE : ST_FIN;
                end
            end
            ST_BASE: begin
                if (last_step) begin
                    n_state = ST_SQR;
                end
            end
            ST_SQR: begin
                if (last_step) begin
                    if (exp_bit) begin
                        n_state = ST_MUL;
                    end else if (r_k == '0) begin
                        n_state = ST_FIN;
                    end
                end
            end
            ST_MUL: begin
                if (last_step) begin
                    n_state = (r_k == '0) ? ST_FIN : ST_SQR;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    load    = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res   <= result;
            r_olast <= r_ctl.last;
        end
        case (r_state)
            ST_IDLE: begin
                if (o_q_pop) begin
                    r_v   <= i_q_base;
                    r_ctl <= i_q_ctl;
                    r_r   <= '0;
                    r_cnt <= '0;
                    r_acc <= '0;
                    r_k   <= KW'(EXP_WIDTH - 1);
                end
            end
            ST_BASE: begin
                r_v <= r_v << 1;
                if (last_step) begin
                    // base reduced, start the first squaring of acc = 1
                    r_b   <= step_r;
                    r_acc <= MOD_WIDTH'(1);
                    r_a   <= MOD_WIDTH'(1);
                    r_y   <= MOD_WIDTH'(1);
                    r_r   <= '0;
                    r_cnt <= '0;
                end else begin
                    r_r   <= step_r;
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            ST_SQR: begin
                if (last_step) begin
                    r_acc <= step_r;
                    r_r   <= '0;
                    r_cnt <= '0;
                    r_y   <= step_r;
                    if (exp_bit) begin
                        r_a <= r_b;
                    end else begin
                        r_a <= step_r;
                        r_k <= r_k - 1'b1;
                    end
                end else begin
                    r_y   <= r_y << 1;
                    r_r   <= step_r;
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            ST_MUL: begin
                if (last_step) begin
                    r_acc <= step_r;
                    r_r   <= '0;
                    r_cnt <= '0;
                    r_a   <= step_r;
                    r_y   <= step_r;
                    r_k   <= r_k - 1'b1;
                end else begin
                    r_y   <= r_y << 1;
                    r_r   <= step_r;
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_valid        = r_out_valid;
    assign o_result_value = r_res;
    assign o_last_out     = r_olast;

endmodule

### hdl/rsa_symbol_modexp_core.sv
// channel   | valid    | ready    | payload
// ----------+----------+----------+------------------------------------
// input     | i_valid  | o_ready  | i_command, i_value, i_is_last
// result    | o_valid  | i_ready  | o_result_value, o_last_out
// config    | i_cfg_we | -        | i_cfg_index, i_cfg_data
//
// in the engine an item first has its base reduced, one bit a cycle, then gets a
// square for each of the 16 exponent bits and a multiply for each one bit; each
// is a 16 step shift-add-reduce loop; at modulus below 2 it goes straight to the final state
// a two entry queue decouples input from the engine; encrypt terminators are dropped
// at the front; the result register holds while i_ready is low
// reset is synchronous, empties the queue, idles the engine, sets exponent 1, modulus 2
module rsa_symbol_modexp_core
    import rsm_pkg::*;
#(
    parameter int VALUE_WIDTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_index,
    input  logic [MOD_WIDTH-1:0]   i_cfg_data,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic                   i_command,
    input  logic [VALUE_WIDTH-1:0] i_value,
    input  logic                   i_is_last,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [VALUE_WIDTH-1:0] o_result_value,
    output logic                   o_last_out
);

    localparam int QW = VALUE_WIDTH + $bits(t_job_ctl);

    t_cfg                   r_cfg;
    logic                   drop;
    logic [VALUE_WIDTH-1:0] f_base;
    t_job_ctl               f_ctl;
    logic                   q_full;
    logic                   q_empty;
    logic                   q_pop;
    logic                   q_push;
    logic [QW-1:0]          q_out;
    t_job_ctl               q_ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.exponent <= EXP_RESET;
            r_cfg.modulus  <= MOD_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_EXPONENT) begin
                r_cfg.exponent <= i_cfg_data;
            end else begin
                r_cfg.modulus <= i_cfg_data;
            end
        end
    end

    rsm_front #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_front (
        .i_command(i_command),
        .i_value  (i_value),
        .i_is_last(i_is_last),
        .o_drop   (drop),
        .o_base   (f_base),
        .o_ctl    (f_ctl)
    );

    assign o_ready = !q_full;
    assign q_push  = i_valid && !q_full && !drop;

    rsm_queue #(
        .W(QW)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_push_data({f_ctl, f_base}),
        .o_full     (q_full),
        .i_pop      (q_pop),
        .o_pop_data (q_out),
        .o_empty    (q_empty)
    );

    assign q_ctl = q_out[QW-1:VALUE_WIDTH];

    rsm_engine #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_q_valid     (!q_empty),
        .i_q_ctl       (q_ctl),
        .i_q_base      (q_out[VALUE_WIDTH-1:0]),
        .o_q_pop       (q_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_result_value(o_result_value),
        .o_last_out    (o_last_out)
    );

endmodule

### hdl/rsm_checker.sv
module rsm_checker #(
    parameter int VALUE_WIDTH = 16
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_ready,
    input logic                   o_valid,
    input logic                   i_ready,
    input logic [VALUE_WIDTH-1:0] o_result_value,
    input logic                   o_last_out
);

    // a stalled result transaction keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result_value) && $stable(o_last_out))
        else $error("result changed while stalled");

    a_rst_no_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_ready)
        else $error("input not ready right after reset");

    // a result has to pass the queue, the engine states and the result register, so none is valid straight after reset
    a_no_early_out: assert property (@(posedge i_clk)
        !i_rst_n ##1 i_rst_n |=> !o_valid)
        else $error("result too early after reset");

endmodule

bind rsa_symbol_modexp_core rsm_checker #(
    .VALUE_WIDTH(VALUE_WIDTH)
) u_rsm_checker (.*);

### dv/tb_rsa_symbol_modexp_core.sv
`timescale 1ns / 100ps

module tb_rsa_symbol_modexp_core;
    import rsm_pkg::*;

    localparam int VW            = 16;
    localparam int SETTLE_CYCLES = 1200;
    localparam int DRAIN_LIMIT   = 40000;
    localparam int STALL_CYCLES  = 4000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_SYMBOLS = 65;
    localparam int MAX_PRINTED   = 150;

    typedef struct packed {
        logic          cmd;
        logic [VW-1:0] value;
        logic          last;
    } symbol_t;

    typedef struct packed {
        logic [VW-1:0] value;
        logic          last;
    } crypt_result_t;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic                 i_cfg_index = CFG_EXPONENT;
    logic [MOD_WIDTH-1:0] i_cfg_data  = '0;
    logic                 i_valid     = 1'b0;
    logic                 o_ready;
    logic                 i_command   = CMD_ENCRYPT;
    logic [VW-1:0]        i_value     = '0;
    logic                 i_is_last   = 1'b0;
    logic                 o_valid;
    logic                 i_ready     = 1'b0;
    logic [VW-1:0]        o_result_value;
    logic                 o_last_out;

    symbol_t       pending_symbols[$];
    crypt_result_t expected_results[$];
    int            symbols_offered = 0;
    int            symbols_taken   = 0;
    int            err_count       = 0;
    logic [EXP_WIDTH-1:0] exp_reg  = EXP_RESET;
    logic [MOD_WIDTH-1:0] mod_reg  = MOD_RESET;
    bit            no_gaps  = 1'b0;
    bit            hold_rx  = 1'b0;
    bit            stall_go = 1'b0;

    rsa_symbol_modexp_core #(
        .VALUE_WIDTH(VW)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_command     (i_command),
        .i_value       (i_value),
        .i_is_last     (i_is_last),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_result_value(o_result_value),
        .o_last_out    (o_last_out)
    );

    always #6 i_clk = ~i_clk;

    task automatic report_mismatch(string what, logic [VW-1:0] got, logic [VW-1:0] want);
        err_count++;
        if (err_count <= MAX_PRINTED) begin
            $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
        end
    endtask

    // square-and-multiply, msb first over all exponent bits
    function automatic logic [VW-1:0] pow_mod(logic [VW-1:0] base, logic [EXP_WIDTH-1:0] e,
                                              logic [MOD_WIDTH-1:0] m);
        logic [31:0] acc;
        logic [31:0] b;
        if (m < 2) begin
            return '0;
        end
        acc = 32'd1;
        b = 32'(base) % 32'(m);
        for (int k = EXP_WIDTH - 1; k >= 0; k--) begin
            acc = (acc * acc) % 32'(m);
            if (e[k]) begin
                acc = (acc * b) % 32'(m);
            end
        end
        return acc[VW-1:0];
    endfunction

    function automatic void predict_symbol(symbol_t s);
        logic [7:0]    ch;
        logic [7:0]    plain;
        crypt_result_t r;
        r.last = s.last;
        if (s.cmd == CMD_ENCRYPT) begin
            ch = s.value[7:0];
            if (ch >= LOWER_BASE && ch <= LOWER_BASE + LETTER_SPAN) begin
                ch = ch - LOWER_BASE;
            end else if (ch >= UPPER_BASE && ch <= UPPER_BASE + LETTER_SPAN) begin
                ch = ch - UPPER_BASE;
            end else if (ch == TERMINATOR) begin
                return;
            end
            r.value = pow_mod({8'h00, ch}, exp_reg, mod_reg);
        end else begin
            plain = 8'(pow_mod(s.value, exp_reg, mod_reg)) + LOWER_BASE;
            r.value = {8'h00, plain};
        end
        expected_results.push_back(r);
    endfunction

    // input side: a transaction is taken here and its result predicted
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) begin
            symbols_taken <= symbols_taken + 1;
            predict_symbol('{cmd: i_command, value: i_value, last: i_is_last});
        end
    end

    always @(negedge i_clk) begin : symbol_driver
        symbol_t s;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && symbols_taken != symbols_offered) begin
            // hold payload until taken
        end else if (pending_symbols.size() != 0 && (no_gaps || $urandom_range(99) >= 9)) begin
            s = pending_symbols.pop_front();
            i_valid         <= 1'b1;
            i_command       <= s.cmd;
            i_value         <= s.value;
            i_is_last       <= s.last;
            symbols_offered <= symbols_offered + 1;
        end else begin
            i_valid <= 1'b0;
        end
    end

    always @(negedge i_clk) begin
        if (hold_rx) begin
            i_ready <= 1'b0;
        end else if (no_gaps) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(99) >= 9);
        end
    end

    // long receiver hold-off so the input queue backs up
    initial begin
        wait (stall_go);
        hold_rx = 1'b1;
        repeat (STALL_CYCLES) @(posedge i_clk);
        hold_rx = 1'b0;
    end

    always @(posedge i_clk) begin : result_monitor
        crypt_result_t want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", o_result_value, '0);
            end else begin
                want = expected_results.pop_front();
                if (o_result_value !== want.value) begin
                    report_mismatch("result_value", o_result_value, want.value);
                end
                if (o_last_out !== want.last) begin
                    report_mismatch("last_out", VW'(o_last_out), VW'(want.last));
                end
            end
        end
    end

    task automatic add_symbol(logic cmd, logic [VW-1:0] value, logic last);
        pending_symbols.push_back('{cmd: cmd, value: value, last: last});
    endtask

    task automatic write_cfg(logic index, logic [MOD_WIDTH-1:0] data);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = index;
        i_cfg_data  = data;
        if (index == CFG_EXPONENT) begin
            exp_reg = data;
        end else begin
            mod_reg = data;
        end
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // wait until every symbol is taken and every result is back, then wait
    // a while longer so a stray extra result still gets caught
    task automatic drain_results();
        int waited;
        crypt_result_t left;
        while (pending_symbols.size() != 0 || symbols_taken != symbols_offered) begin
            @(posedge i_clk);
        end
        waited = 0;
        while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (expected_results.size() != 0) begin
            left = expected_results.pop_front();
            report_mismatch("missing result", '0, left.value);
        end
    endtask

    // well-formed messages mostly, with some noise mixed in
    task automatic fill_random(int target);
        int   made;
        int   kind;
        int   len;
        logic [7:0] ch;
        logic [7:0] hi;
        logic [VW-1:0] v;
        made = 0;
        while (made < target) begin
            kind = $urandom_range(99);
            if (kind < 55) begin
                len = $urandom_range(8, 1);
                for (int i = 0; i < len; i++) begin
                    ch = ($urandom_range(1) ? LOWER_BASE : UPPER_BASE) +
                         8'($urandom_range(LETTER_SPAN));
                    hi = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'h00;
                    add_symbol(CMD_ENCRYPT, {hi, ch}, i == len - 1);
                    made++;
                end
                if ($urandom_range(1)) begin
                    hi = ($urandom_range(4) == 0) ? 8'($urandom_range(255)) : 8'h00;
                    add_symbol(CMD_ENCRYPT, {hi, TERMINATOR}, 1'($urandom_range(1)));
                end
            end else if (kind < 80) begin
                len = $urandom_range(6, 1);
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(1) && mod_reg != 0) begin
                        v = VW'($urandom_range(mod_reg - 1));
                    end else begin
                        v = VW'($urandom_range(65535));
                    end
                    add_symbol(CMD_DECRYPT, v, i == len - 1);
                    made++;
                end
            end else begin
                v = VW'($urandom_range(65535));
                if ($urandom_range(1)) begin
                    add_symbol(CMD_DECRYPT, v, 1'($urandom_range(1)));
                    made++;
                end else begin
                    add_symbol(CMD_ENCRYPT, v, 1'($urandom_range(1)));
                    if (v[7:0] != TERMINATOR) begin
                        made++;
                    end
                end
            end
        end
    endtask

    initial begin
        logic [EXP_WIDTH-1:0] e;
        logic [MOD_WIDTH-1:0] m;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset configuration: letters at both ends, non-letters, wide bytes
        add_symbol(CMD_ENCRYPT, 16'h0061, 1'b0);
        add_symbol(CMD_ENCRYPT, 16'h007A, 1'b0);
        add_symbol(CMD_ENCRYPT, 16'h0041, 1'b0);
        add_symbol(CMD_ENCRYPT, 16'h005A, 1'b1);
        add_symbol(CMD_ENCRYPT, {8'h00, TERMINATOR}, 1'b1);
        add_symbol(CMD_ENCRYPT, 16'h0000, 1'b0);
        add_symbol(CMD_ENCRYPT, 16'h00FF, 1'b1);
        add_symbol(CMD_ENCRYPT, {8'hFF, TERMINATOR}, 1'b0);
        add_symbol(CMD_ENCRYPT, 16'hA561, 1'b0);
        add_symbol(CMD_DECRYPT, 16'h0000, 1'b0);
        add_symbol(CMD_DECRYPT, 16'hFFFF, 1'b1);
        drain_results();

        write_cfg(CFG_EXPONENT, 16'd17);
        write_cfg(CFG_MODULUS, 16'd3233);
        add_symbol(CMD_ENCRYPT, 16'h0068, 1'b0);
        add_symbol(CMD_ENCRYPT, 16'h0069, 1'b1);
        add_symbol(CMD_ENCRYPT, 16'h0040, 1'b0);
        add_symbol(CMD_ENCRYPT, 16'h005B, 1'b0);
        add_symbol(CMD_ENCRYPT, 16'h0060, 1'b0);
        add_symbol(CMD_ENCRYPT, 16'h007B, 1'b1);
        add_symbol(CMD_ENCRYPT, {8'h00, TERMINATOR}, 1'b0);
        add_symbol(CMD_DECRYPT, 16'd3232, 1'b1);
        drain_results();

        // zero exponent, so even 0^0 gives one
        write_cfg(CFG_EXPONENT, 16'd0);
        write_cfg(CFG_MODULUS, 16'hFFFF);
        add_symbol(CMD_ENCRYPT, 16'h0000, 1'b0);
        add_symbol(CMD_DECRYPT, 16'h0000, 1'b1);
        drain_results();

        // degenerate modulus values
        write_cfg(CFG_EXPONENT, 16'hFFFF);
        write_cfg(CFG_MODULUS, 16'd1);
        add_symbol(CMD_ENCRYPT, 16'h0071, 1'b0);
        add_symbol(CMD_DECRYPT, 16'd5, 1'b1);
        drain_results();
        write_cfg(CFG_MODULUS, 16'd0);
        add_symbol(CMD_DECRYPT, 16'd9, 1'b1);
        drain_results();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: begin
                    e = 16'hFFFF;
                    m = 16'hFFFF;
                end
                1: begin
                    e = 16'hFFFF;
                    m = 16'd2;
                end
                default: begin
                    e = EXP_WIDTH'($urandom_range(65535));
                    m = (p % 2) ? MOD_WIDTH'($urandom_range(65535, 2))
                                : MOD_WIDTH'($urandom_range(400, 2));
                end
            endcase
            write_cfg(CFG_EXPONENT, e);
            write_cfg(CFG_MODULUS, m);
            no_gaps = (p == 3);
            if (p == 5) begin
                stall_go = 1'b1;
            end
            fill_random(PHASE_SYMBOLS);
            drain_results();
            no_gaps = 1'b0;
        end

        if (err_count == 0) begin
            $display("[rsa_symbol_modexp_core] OK");
        end else begin
            $display("[rsa_symbol_modexp_core] ERROR");
        end
        $finish;
    end

    initial begin
        #(30_000_000);
        $display("[rsa_symbol_modexp_core] ERROR");
        $finish;
    end

endmodule

### files.f
hdl/rsm_pkg.sv
hdl/rsm_front.sv
hdl/rsm_queue.sv
hdl/rsm_engine.sv
hdl/rsa_symbol_modexp_core.sv
hdl/rsm_checker.sv
dv/tb_rsa_symbol_modexp_core.sv
